### src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Used by rau_ctrl, rau_dpath and rational_arithmetic_unit; no dependencies.
`timescale 1ns / 1ps

package rau_pkg;

  // Operand width of every input numerator and denominator.
  localparam int OPERAND_W = 16;
  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 31;
  localparam int CNT_W     = $clog2(OPERAND_W);

  // Opcodes.
  localparam logic [1:0] OP_NORM   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_MUL    = 2'd2;
  localparam logic [1:0] OP_REDUCE = 2'd3;

  // Multiplier operand pairs.
  localparam logic [1:0] MUL_DEN = 2'd0;  // a_den * b_den
  localparam logic [1:0] MUL_AB  = 2'd1;  // a_num * b_den
  localparam logic [1:0] MUL_BA  = 2'd2;  // b_num * a_den
  localparam logic [1:0] MUL_NN  = 2'd3;  // a_num * b_num

  // Divider operand pairs.
  localparam logic [1:0] DIV_GCD = 2'd0;  // x % y of the Euclid loop
  localparam logic [1:0] DIV_NUM = 2'd1;  // |a_num| / gcd
  localparam logic [1:0] DIV_DEN = 2'd2;  // a_den / gcd

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [OPERAND_W-1:0] a_num;
    logic signed [OPERAND_W-1:0] a_den;
    logic signed [OPERAND_W-1:0] b_num;
    logic signed [OPERAND_W-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        bad_denominator;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       set_bad;
    logic       set_norm;
    logic       prod_en;
    logic [1:0] mul_sel;
    logic       den_from_prod;
    logic       num_from_prod;
    logic       num_add_prod;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_start;
    logic [1:0] div_src;
    logic       num_from_quo;
    logic       den_from_quo;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       bad;
    logic       y_zero;
    logic       div_done;
  } sts_t;

endpackage

### src/rau_dpath.sv
// Datapath of the rational arithmetic unit: request register, shared multiplier,
// Euclid registers, restoring divider and result register. Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_dpath
  import rau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  req_t in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t out_data
);

  req_t                        req_r;
  logic [RES_NUM_W-1:0]        prod_r;
  logic [RES_NUM_W-1:0]        num_r;
  logic [RES_DEN_W-1:0]        den_r;
  logic                        bad_r;
  logic [OPERAND_W-1:0]        x_r;
  logic [OPERAND_W-1:0]        y_r;
  logic [OPERAND_W-1:0]        rem_r;
  logic [OPERAND_W-1:0]        quo_r;
  logic [OPERAND_W-1:0]        dsr_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  rsp_t                        out_r;

  logic signed [OPERAND_W-1:0]   mul_a;
  logic signed [OPERAND_W-1:0]   mul_b;
  logic signed [2*OPERAND_W-1:0] prod_full;
  logic [OPERAND_W-1:0]          a_mag;
  logic [OPERAND_W-1:0]          dvd;
  logic [OPERAND_W-1:0]          dsr;
  logic [OPERAND_W:0]            div_sh;
  logic [OPERAND_W:0]            div_diff;
  logic [RES_NUM_W-1:0]          a_num_x;
  logic [RES_NUM_W-1:0]          a_den_x;
  logic                          a_den_neg;
  logic                          a_den_zero;
  logic                          b_den_bad;
  logic                          den_bad;

  assign a_den_neg  = req_r.a_den[OPERAND_W-1];
  assign a_den_zero = (req_r.a_den == '0);
  assign b_den_bad  = req_r.b_den[OPERAND_W-1] | (req_r.b_den == '0);
  assign a_mag      = req_r.a_num[OPERAND_W-1] ? (OPERAND_W'(0) - req_r.a_num)
                                               : req_r.a_num;
  assign a_num_x    = RES_NUM_W'(req_r.a_num);
  assign a_den_x    = RES_NUM_W'(req_r.a_den);

  always_comb begin
    unique case (req_r.opcode)
      OP_NORM:         den_bad = a_den_zero;
      OP_ADD, OP_MUL:  den_bad = a_den_neg | a_den_zero | b_den_bad;
      default:         den_bad = a_den_neg | a_den_zero;
    endcase
  end

  assign sts.bad      = den_bad;
  assign sts.opcode   = req_r.opcode;
  assign sts.y_zero   = (y_r == '0);
  assign sts.div_done = done_r;

  // Shared multiplier; only the low 32 bits of any product are kept.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DEN: begin mul_a = req_r.a_den; mul_b = req_r.b_den; end
      MUL_AB:  begin mul_a = req_r.a_num; mul_b = req_r.b_den; end
      MUL_BA:  begin mul_a = req_r.b_num; mul_b = req_r.a_den; end
      default: begin mul_a = req_r.a_num; mul_b = req_r.b_num; end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_comb begin
    unique case (cmd.div_src)
      DIV_GCD: begin dvd = x_r;         dsr = y_r; end
      DIV_NUM: begin dvd = a_mag;       dsr = x_r; end
      DIV_DEN: begin dvd = req_r.a_den; dsr = x_r; end
      default: begin dvd = x_r;         dsr = y_r; end
    endcase
  end

  // One restoring step per cycle: the partial remainder always stays below the divisor.
  assign div_sh   = {rem_r, quo_r[OPERAND_W-1]};
  assign div_diff = div_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.div_start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(OPERAND_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= dvd;
      dsr_r <= dsr;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (!div_diff[OPERAND_W]) begin
        rem_r <= div_diff[OPERAND_W-1:0];
        quo_r <= {quo_r[OPERAND_W-2:0], 1'b1};
      end else begin
        rem_r <= div_sh[OPERAND_W-1:0];
        quo_r <= {quo_r[OPERAND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.prod_en) begin
      prod_r <= RES_NUM_W'(prod_full);
    end
    if (cmd.gcd_init) begin
      x_r <= a_mag;
      y_r <= req_r.a_den;
    end else if (cmd.gcd_step) begin
      x_r <= y_r;
      y_r <= rem_r;
    end
    if (cmd.set_bad) begin
      num_r <= '0;
      den_r <= '0;
      bad_r <= 1'b1;
    end else if (cmd.set_norm) begin
      bad_r <= 1'b0;
      if (a_den_neg) begin
        num_r <= RES_NUM_W'(0) - a_num_x;
        den_r <= RES_DEN_W'(RES_NUM_W'(0) - a_den_x);
      end else begin
        num_r <= a_num_x;
        den_r <= RES_DEN_W'(a_den_x);
      end
    end else begin
      if (cmd.den_from_prod) begin
        den_r <= RES_DEN_W'(prod_r);
        bad_r <= 1'b0;
      end
      if (cmd.num_from_prod) begin
        num_r <= prod_r;
      end else if (cmd.num_add_prod) begin
        num_r <= num_r + prod_r;
      end else if (cmd.num_from_quo) begin
        num_r <= req_r.a_num[OPERAND_W-1] ? (RES_NUM_W'(0) - RES_NUM_W'(quo_r))
                                          : RES_NUM_W'(quo_r);
        bad_r <= 1'b0;
      end
      if (cmd.den_from_quo) begin
        den_r <= RES_DEN_W'(quo_r);
      end
    end
    if (cmd.out_ld) begin
      out_r.res_num         <= num_r;
      out_r.res_den         <= den_r;
      out_r.bad_denominator <= bad_r;
    end
  end

  assign out_data = out_r;

endmodule

### src/rau_ctrl.sv
// Sequencing state machine of the rational arithmetic unit and the result valid flag.
// Drives the datapath through cmd_t and reads sts_t; depends on rau_pkg.
`timescale 1ns / 1ps

module rau_ctrl
  import rau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_MUL3  = 4'd4;
  localparam logic [3:0] S_GCD   = 4'd5;
  localparam logic [3:0] S_GWAIT = 4'd6;
  localparam logic [3:0] S_QNUM  = 4'd7;
  localparam logic [3:0] S_QDEN  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.bad) begin
          cmd.set_bad = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          unique case (sts.opcode)
            OP_NORM: begin
              cmd.set_norm = 1'b1;
              state_nxt    = S_OUT;
            end
            OP_ADD, OP_MUL: begin
              cmd.prod_en = 1'b1;
              cmd.mul_sel = MUL_DEN;
              state_nxt   = S_MUL1;
            end
            default: begin
              cmd.gcd_init = 1'b1;
              state_nxt    = S_GCD;
            end
          endcase
        end
      end
      S_MUL1: begin
        cmd.den_from_prod = 1'b1;
        cmd.prod_en       = 1'b1;
        cmd.mul_sel       = (sts.opcode == OP_ADD) ? MUL_AB : MUL_NN;
        state_nxt         = S_MUL2;
      end
      S_MUL2: begin
        cmd.num_from_prod = 1'b1;
        if (sts.opcode == OP_ADD) begin
          cmd.prod_en = 1'b1;
          cmd.mul_sel = MUL_BA;
          state_nxt   = S_MUL3;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MUL3: begin
        cmd.num_add_prod = 1'b1;
        state_nxt        = S_OUT;
      end
      S_GCD: begin
        // Once the remainder runs out, x holds the gcd and the quotients follow.
        cmd.div_start = 1'b1;
        if (sts.y_zero) begin
          cmd.div_src = DIV_NUM;
          state_nxt   = S_QNUM;
        end else begin
          cmd.div_src = DIV_GCD;
          state_nxt   = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (sts.div_done) begin
          cmd.gcd_step = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      S_QNUM: begin
        if (sts.div_done) begin
          cmd.num_from_quo = 1'b1;
          cmd.div_start    = 1'b1;
          cmd.div_src      = DIV_DEN;
          state_nxt        = S_QDEN;
        end
      end
      S_QDEN: begin
        if (sts.div_done) begin
          cmd.den_from_quo = 1'b1;
          state_nxt        = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: joins controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_dpath.
//
//   Channel  Ports                           Direction  Payload
//   request  in_valid, in_ready, in_data     in         req_t
//   result   out_valid, out_ready, out_data  out        rsp_t
//
// One request is worked on at a time; a new one is taken once the previous
// result has moved into the output register, so that register may still wait.
// Normalize or a bad denominator goes straight to the result; multiply and add
// use the single shared multiplier in turn. Reduce runs its Euclid remainder
// steps, then two quotients, on the restoring divider at one bit per cycle.
// Reset is synchronous and clears only control state; a stalled result holds.
`timescale 1ns / 1ps

module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
